// ===== design/mexp_pkg.sv =====
package mexp_pkg;

    // Default widths of the modulus and the exponent
    localparam int MOD_WIDTH_DEF = 31;
    localparam int EXP_WIDTH_DEF = 63;

    // Width of the base operand; the multiplier register holds one full base
    localparam int BASE_W = 32;

    // Step counter: must hold BASE_W itself
    localparam int CNT_W = $clog2(BASE_W + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RED,
        S_CHECK,
        S_MUL,
        S_SQR,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic start_mul;
        logic start_sqr;
        logic step;
        logic wb_acc;
        logic wb_base;
        logic shift_exp;
    } t_cmd;

    typedef struct packed {
        logic mod_lt2;
        logic exp_zero;
        logic exp_lsb;
        logic last;
    } t_status;

endpackage

// ===== design/mexp_ctrl.sv =====
module mexp_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  mexp_pkg::t_status i_sts,
    output mexp_pkg::t_cmd   o_cmd,
    output logic             o_busy,
    output logic             o_done
);
    import mexp_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_busy  = (r_state != S_IDLE);
        o_done  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_sts.mod_lt2 ? S_DONE : S_RED;
                end
            end
            S_RED: begin
                o_cmd.step = 1'b1;
                if (i_sts.last) begin
                    o_cmd.wb_base = 1'b1;
                    n_state       = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_sts.exp_zero) begin
                    n_state = S_DONE;
                end else if (i_sts.exp_lsb) begin
                    o_cmd.start_mul = 1'b1;
                    n_state         = S_MUL;
                end else begin
                    o_cmd.start_sqr = 1'b1;
                    n_state         = S_SQR;
                end
            end
            S_MUL: begin
                o_cmd.step = 1'b1;
                if (i_sts.last) begin
                    // base is untouched by this multiply: chain the square
                    o_cmd.wb_acc    = 1'b1;
                    o_cmd.start_sqr = 1'b1;
                    n_state         = S_SQR;
                end
            end
            S_SQR: begin
                o_cmd.step = 1'b1;
                if (i_sts.last) begin
                    o_cmd.wb_base   = 1'b1;
                    o_cmd.shift_exp = 1'b1;
                    n_state         = S_CHECK;
                end
            end
            S_DONE: begin
                o_done  = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== design/mexp_datapath.sv =====
module mexp_datapath #(
    parameter int MOD_WIDTH = mexp_pkg::MOD_WIDTH_DEF,
    parameter int EXP_WIDTH = mexp_pkg::EXP_WIDTH_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [MOD_WIDTH-1:0]      i_cfg_data,
    input  logic                      i_op,
    input  logic [mexp_pkg::BASE_W-1:0] i_base_value,
    input  logic [EXP_WIDTH-1:0]      i_exponent,
    input  mexp_pkg::t_cmd            i_cmd,
    output mexp_pkg::t_status         o_sts,
    output logic [MOD_WIDTH-1:0]      o_result
);
    import mexp_pkg::*;

    localparam int EW   = (EXP_WIDTH > MOD_WIDTH) ? EXP_WIDTH : MOD_WIDTH;
    localparam int PAD  = BASE_W - MOD_WIDTH;
    localparam int SW   = MOD_WIDTH + 3;

    logic [MOD_WIDTH-1:0] r_mod;
    logic [MOD_WIDTH-1:0] r_acc;
    logic [MOD_WIDTH-1:0] r_base;
    logic [EW-1:0]        r_exp;
    logic [MOD_WIDTH-1:0] r_prod;
    logic [MOD_WIDTH-1:0] r_mcand;
    logic [BASE_W-1:0]    r_mplr;
    logic [CNT_W-1:0]     r_cnt;

    logic [SW-1:0]        w_sum;
    logic [SW-1:0]        w_sub1;
    logic [SW-1:0]        w_sub2;
    logic [MOD_WIDTH-1:0] n_prod;
    logic [MOD_WIDTH-1:0] w_mul_src;

    // One multiplier bit per cycle, MSB first: prod = 2*prod + bit*mcand mod m.
    // prod, mcand < m, so the sum stays below 3m; pick among sum, sum-m, sum-2m.
    always_comb begin
        w_sum  = {2'b00, r_prod, 1'b0}
               + (r_mplr[BASE_W-1] ? {3'b000, r_mcand} : '0);
        w_sub1 = w_sum - {3'b000, r_mod};
        w_sub2 = w_sum - {2'b00, r_mod, 1'b0};
        if (!w_sub2[SW-1]) begin
            n_prod = w_sub2[MOD_WIDTH-1:0];
        end else if (!w_sub1[SW-1]) begin
            n_prod = w_sub1[MOD_WIDTH-1:0];
        end else begin
            n_prod = w_sum[MOD_WIDTH-1:0];
        end
    end

    assign w_mul_src = i_cmd.start_mul ? r_acc : r_base;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mod <= {MOD_WIDTH{1'b1}};
        end else if (i_cfg_we) begin
            r_mod <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            // base mod m is computed as 1 * base over all base bits
            r_prod  <= '0;
            r_mcand <= MOD_WIDTH'(1);
            r_mplr  <= i_base_value;
            r_cnt   <= CNT_W'(BASE_W);
        end else if (i_cmd.start_mul || i_cmd.start_sqr) begin
            r_prod  <= '0;
            r_mcand <= w_mul_src;
            r_mplr  <= {r_base, {PAD{1'b0}}};
            r_cnt   <= CNT_W'(MOD_WIDTH);
        end else if (i_cmd.step) begin
            r_prod  <= n_prod;
            r_mplr  <= {r_mplr[BASE_W-2:0], 1'b0};
            r_cnt   <= r_cnt - CNT_W'(1);
        end

        if (i_cmd.load) begin
            r_acc <= (r_mod < MOD_WIDTH'(2)) ? '0 : MOD_WIDTH'(1);
        end else if (i_cmd.wb_acc) begin
            r_acc <= n_prod;
        end

        if (i_cmd.wb_base) begin
            r_base <= n_prod;
        end

        if (i_cmd.load) begin
            r_exp <= i_op ? EW'(r_mod - MOD_WIDTH'(2)) : EW'(i_exponent);
        end else if (i_cmd.shift_exp) begin
            r_exp <= {1'b0, r_exp[EW-1:1]};
        end
    end

    assign o_sts.mod_lt2  = (r_mod < MOD_WIDTH'(2));
    assign o_sts.exp_zero = (r_exp == '0);
    assign o_sts.exp_lsb  = r_exp[0];
    assign o_sts.last     = (r_cnt == CNT_W'(1));
    assign o_result       = r_acc;

endmodule

// ===== design/modular_exponentiation_core.sv =====
// Modular exponentiation core: computes base^exponent mod modulus by
// right-to-left square-and-multiply, or the Fermat inverse base^(modulus-2)
// when i_op is high (exponent ignored; a prime modulus is assumed). The
// modulus is a register written through i_cfg_we / i_cfg_data, resetting to
// all ones; write it only while busy is low. An item is taken on a clock edge
// where start is high and busy is low. The result beat appears on o_result for
// exactly one cycle with o_done high; the receiver cannot stall it, so sample
// it on that cycle. All arithmetic runs on one bit-serial modular multiplier
// that consumes one multiplier bit per cycle. An item first reduces the base,
// then for each exponent bit up to the highest set bit multiplies (if the bit
// is set) and squares. A modulus of 0 or 1 yields 0 in the cycle after the
// accepting edge.
module modular_exponentiation_core #(
    parameter int MOD_WIDTH = mexp_pkg::MOD_WIDTH_DEF,
    parameter int EXP_WIDTH = mexp_pkg::EXP_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // command channel
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_op,
    input  logic [mexp_pkg::BASE_W-1:0]   i_base_value,
    input  logic [EXP_WIDTH-1:0]          i_exponent,
    // modulus register
    input  logic                          i_cfg_we,
    input  logic [MOD_WIDTH-1:0]          i_cfg_data,
    // result beat
    output logic                          o_done,
    output logic [MOD_WIDTH-1:0]          o_result
);
    import mexp_pkg::*;

    t_cmd    w_cmd;
    t_status w_sts;

    // Sequencer: reduce base, then per exponent bit multiply (if set) and square
    mexp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd),
        .o_busy  (busy),
        .o_done  (o_done)
    );

    // Operand registers, modulus register and the shared modular multiplier
    mexp_datapath #(
        .MOD_WIDTH (MOD_WIDTH),
        .EXP_WIDTH (EXP_WIDTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_op         (i_op),
        .i_base_value (i_base_value),
        .i_exponent   (i_exponent),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .o_result     (o_result)
    );

endmodule

// ===== design/mexp_checker.sv =====
module mexp_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_done
);

    // A result beat only shows up while an item is in flight
    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> busy)
        else $error("result beat outside an item");

    // An accepted item makes the core busy on the next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not raise busy");

    // Exactly one beat per item: the core frees up right after the beat
    a_done_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !busy)
        else $error("busy held after result beat");

    // Busy drops only after a result beat
    a_fall_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> $past(o_done))
        else $error("item finished without a result beat");

endmodule

bind modular_exponentiation_core mexp_checker u_mexp_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .o_done  (o_done)
);

// ===== test/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
    import mexp_pkg::*;

    localparam int MOD_W = 31;
    localparam int EXP_W = 63;

    // Operation select on i_op
    localparam bit OP_POWER   = 1'b0;
    localparam bit OP_INVERSE = 1'b1;

    // Give up after this many cycles in which no beat moves on either side.
    localparam int WATCHDOG_LIMIT = 20000;

    localparam bit [MOD_W-1:0] MOD_RESET = '1;

    typedef struct {
        bit               op;
        bit [BASE_W-1:0]  base;
        bit [EXP_W-1:0]   expo;
    } t_power_req;

    typedef struct {
        t_power_req       req;
        bit [MOD_W-1:0]   modulus;
        bit [MOD_W-1:0]   value;
    } t_power_result;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic               i_op = 1'b0;
    logic [BASE_W-1:0]  i_base_value = '0;
    logic [EXP_W-1:0]   i_exponent = '0;
    logic               i_cfg_we = 1'b0;
    logic [MOD_W-1:0]   i_cfg_data = '0;
    logic               o_done;
    logic [MOD_W-1:0]   o_result;

    t_power_req    pending_reqs[$];       // items not yet offered to the core
    t_power_result expected_powers[$];    // predicted results, oldest first
    bit [MOD_W-1:0] modulus_copy = MOD_RESET;
    int             gap_left = 0;
    int             mismatch_count = 0;
    int             quiet_cycles = 0;

    modular_exponentiation_core #(
        .MOD_WIDTH (MOD_W),
        .EXP_WIDTH (EXP_W)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_op         (i_op),
        .i_base_value (i_base_value),
        .i_exponent   (i_exponent),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .o_done       (o_done),
        .o_result     (o_result)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Right-to-left square-and-multiply on 64-bit words; the modulus is below
    // 2^31, so no product can overflow.
    function automatic bit [MOD_W-1:0] predict_power(t_power_req req, bit [MOD_W-1:0] m);
        bit [63:0] acc;
        bit [63:0] sq;
        bit [63:0] ex;
        bit [63:0] mm;
        mm = m;
        // A modulus of 0 or 1 forces a zero result in both modes
        if (mm < 2)
            return '0;
        // Inverse mode: Fermat power modulus - 2, the exponent field is dropped
        ex  = (req.op == OP_INVERSE) ? mm - 2 : 64'(req.expo);
        sq  = 64'(req.base) % mm;
        acc = 1;
        while (ex != 0) begin
            if (ex[0])
                acc = (acc * sq) % mm;
            sq = (sq * sq) % mm;
            ex = ex >> 1;
        end
        return acc[MOD_W-1:0];
    endfunction

    // Mostly back-to-back or short gaps, now and then a long one
    function automatic int draw_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 4);
        else
            return $urandom_range(20, 80);
    endfunction

    // Driver: offer queued items on the command channel. Hold the fields and
    // start while busy; on an accepting edge record the prediction, then either
    // present the next item at once or idle for a random gap.
    always @(posedge i_clk) begin : drive_commands
        bit         accepted;
        int         gap;
        t_power_req nxt;
        if (!i_rst_n) begin
            start    <= 1'b0;
            gap_left <= 0;
        end else begin
            accepted = start && !busy;
            if (accepted) begin
                t_power_result pr;
                pr.req.op   = i_op;
                pr.req.base = i_base_value;
                pr.req.expo = i_exponent;
                pr.modulus  = modulus_copy;
                pr.value    = predict_power(pr.req, modulus_copy);
                expected_powers = {expected_powers, pr};
            end
            gap = accepted ? draw_gap() : gap_left;
            if (start && !accepted) begin
                // hold the current beat
            end else if (gap == 0 && pending_reqs.size() != 0) begin
                nxt = pending_reqs.pop_front();
                start        <= 1'b1;
                i_op         <= nxt.op;
                i_base_value <= nxt.base;
                i_exponent   <= nxt.expo;
                gap_left     <= 0;
            end else begin
                start    <= 1'b0;
                gap_left <= (gap > 0) ? gap - 1 : 0;
            end
        end
    end

    // Track the modulus register the same way the core does
    always @(posedge i_clk) begin
        if (i_rst_n && i_cfg_we)
            modulus_copy <= i_cfg_data;
    end

    // Monitor: every o_done cycle must match the oldest prediction
    always @(posedge i_clk) begin : check_results
        t_power_result pr;
        if (i_rst_n && o_done) begin
            if (expected_powers.size() == 0) begin
                $display("%0t: unexpected result beat, expected none, got %0d",
                         $time, o_result);
                mismatch_count++;
            end else begin
                pr = expected_powers.pop_front();
                if (o_result !== pr.value) begin
                    $display({"%0t: result mismatch (op %0d base %0d exp %0d mod %0d):",
                              " expected %0d, got %0d"},
                             $time, pr.req.op, pr.req.base, pr.req.expo, pr.modulus,
                             pr.value, o_result);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog: count cycles in which neither a command nor a result moves
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired with %0d results outstanding",
                     $time, expected_powers.size());
            $display("testbench NOT OK");
            $finish;
        end
    end

    task automatic queue_req(bit op, bit [BASE_W-1:0] base, bit [EXP_W-1:0] expo);
        t_power_req req;
        req.op   = op;
        req.base = base;
        req.expo = expo;
        pending_reqs = {pending_reqs, req};
    endtask

    // Advance until the sender has drained and every predicted result is back;
    // look at the falling edge so the driver's updates have settled
    task automatic wait_drained();
        do
            @(negedge i_clk);
        while (pending_reqs.size() != 0 || start || busy || expected_powers.size() != 0);
    endtask

    // Drain, then write the modulus register while the core sits idle
    task automatic set_modulus(bit [MOD_W-1:0] m);
        wait_drained();
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= m;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        i_cfg_data <= MOD_W'($urandom);
        @(posedge i_clk);
    endtask

    // Base mix: zero, multiples of the modulus, all ones, tiny and full random
    function automatic bit [BASE_W-1:0] random_base(bit [MOD_W-1:0] m);
        bit [63:0] k;
        case ($urandom_range(0, 9))
            0: return '0;
            1: begin
                if (m < 2)
                    return $urandom;
                k = $urandom_range(1, 32'hFFFF_FFFF / m);
                return BASE_W'(k * m);
            end
            2: return '1;
            3: return $urandom_range(1, 3);
            default: return $urandom;
        endcase
    endfunction

    // Exponent of random bit length, so the item latency varies
    function automatic bit [EXP_W-1:0] random_exponent();
        bit [63:0] raw;
        int        len;
        raw = {$urandom, $urandom};
        len = $urandom_range(0, EXP_W);
        raw = raw & ((64'd1 << len) - 1);
        return raw[EXP_W-1:0];
    endfunction

    task automatic random_phase(bit [MOD_W-1:0] m, int count);
        bit op;
        set_modulus(m);
        repeat (count) begin
            op = ($urandom_range(0, 3) == 0) ? OP_INVERSE : OP_POWER;
            queue_req(op, random_base(m), random_exponent());
        end
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset modulus (largest 31-bit prime): field extremes and both modes
        queue_req(OP_POWER,   '0, '0);                 // zero to the power zero
        queue_req(OP_POWER,   32'd5, '0);              // zero exponent
        queue_req(OP_POWER,   '1, '1);                 // all-ones base and exponent
        queue_req(OP_POWER,   '0, 63'd5);
        queue_req(OP_POWER,   32'd2, 63'd1);
        queue_req(OP_POWER,   32'd3, 63'h4000_0000_0000_0000);
        queue_req(OP_INVERSE, 32'd3, '1);              // exponent ignored
        queue_req(OP_INVERSE, 32'h7FFF_FFFF, 63'd9);   // multiple of modulus: no inverse
        queue_req(OP_INVERSE, 32'hFFFF_FFFE, '0);      // twice the modulus

        // Modulus 2: inverse power is zero, so always 1
        set_modulus(31'd2);
        queue_req(OP_INVERSE, '0, 63'd7);
        queue_req(OP_INVERSE, 32'd7, '0);
        queue_req(OP_POWER,   32'd4, 63'd3);
        queue_req(OP_POWER,   32'd3, '0);

        // Degenerate moduli give 0 in both modes and for any exponent
        set_modulus(31'd0);
        queue_req(OP_POWER,   32'd9, '0);
        queue_req(OP_INVERSE, 32'd9, 63'd3);
        set_modulus(31'd1);
        queue_req(OP_POWER,   '1, '0);
        queue_req(OP_INVERSE, 32'd5, '1);

        // Non-prime modulus, both modes: inverse mode gives a plain power, not a true inverse
        set_modulus(31'd1_000_000);
        queue_req(OP_INVERSE, 32'd3, '0);
        queue_req(OP_INVERSE, 32'd1_000_000, '0);
        queue_req(OP_POWER,   32'd999_999, 63'd12345);

        // Random part over several moduli, extremes among them
        random_phase(MOD_RESET, 18);
        random_phase(31'd3, 16);
        random_phase(31'd65521, 17);
        random_phase(31'($urandom_range(2, 32'h7FFF_FFFF)), 17);
        random_phase(31'd1_000_003, 17);
        random_phase(31'($urandom_range(1, 32'h3FFF_FFFF)) << 1, 16);
        random_phase(31'd2, 8);
        random_phase(31'h7FFF_FFFE, 16);

        // Drain, then leave room for any stray beat
        wait_drained();
        repeat (100) @(posedge i_clk);
        if (mismatch_count == 0 && expected_powers.size() == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule
